FILE: design/digital_to_analog_axis_ramp_assert.svh
// Assertion macros used by the digital to analog axis ramp controller.
`ifndef DIGITAL_TO_ANALOG_AXIS_RAMP_ASSERT_SVH
`define DIGITAL_TO_ANALOG_AXIS_RAMP_ASSERT_SVH

// Checks a property at every rising edge while the block is out of reset.
`define DAR_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property at every rising edge, reset included.
`define DAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dar_pkg.sv
// Types, codes and constants shared by the axis ramp modules.
package dar_pkg;

    localparam int MAX_AXES    = 6;
    localparam int PORT_IW     = 3;
    localparam int AXIS_IW     = 3;
    localparam int ADDR_MW     = 6;
    localparam int VAL_W       = 16;
    localparam int RATE_W      = 16;
    localparam int ELAPSED_W   = 16;
    localparam int HELD_W      = 12;
    localparam int PORT_FW     = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 104;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;
    localparam logic [31:0]       ROUND_HALF = 32'd128;

    typedef enum logic {
        FUNC_UPDATE = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_NEG  = 2'd1,
        DIR_POS  = 2'd2,
        DIR_BOTH = 2'd3
    } t_dir;

    typedef struct packed {
        logic               accept;
        logic               mult;
        logic               sat;
        logic               rd_en;
        logic [ADDR_MW-1:0] addr;
        logic [PORT_IW-1:0] port;
        logic [AXIS_IW-1:0] axis;
        logic               emit;
        logic               last_port;
    } t_cmd;

    typedef struct packed {
        logic ramp_enabled;
        logic out_free;
    } t_status;

    function automatic logic signed [VAL_W-1:0] clamp_s16(input logic signed [17:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/dar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/dar_ctrl.sv
// Controller that sequences ticks over the ports and axes of the ramp datapath.
`include "digital_to_analog_axis_ramp_assert.svh"

module dar_ctrl import dar_pkg::*; #(
    parameter int PORTS         = 4,
    parameter int AXES_PER_PORT = 6
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_func,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int NENT = PORTS * AXES_PER_PORT;
    localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int PW   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int KW   = (AXES_PER_PORT > 1) ? $clog2(AXES_PER_PORT) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_SAT,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_addr;
    logic [PW-1:0] r_p;
    logic [KW-1:0] r_k;
    logic          w_accept;
    logic          w_last_port;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_port = (r_p == PW'(PORTS - 1));

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = w_accept;
        o_cmd.mult      = (r_state == S_MULT);
        o_cmd.sat       = (r_state == S_SAT);
        o_cmd.rd_en     = (r_state == S_READ);
        o_cmd.addr      = ADDR_MW'(r_addr);
        o_cmd.port      = PORT_IW'(r_p);
        o_cmd.axis      = AXIS_IW'(r_k);
        o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.last_port = w_last_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_p     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (t_func'(i_in_func) == FUNC_TICK)
                            && i_status.ramp_enabled) begin
                        r_state <= S_MULT;
                    end
                end
                S_MULT: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_addr  <= '0;
                    r_p     <= '0;
                    r_k     <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_k == KW'(AXES_PER_PORT - 1)) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (w_last_port) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_p     <= r_p + PW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `DAR_ASSERT_ALWAYS(a_idle_after_reset, i_clk, $past(!i_rst_n) |-> (r_state == S_IDLE), "controller not idle after reset")
    `DAR_ASSERT_RST(a_no_read_when_ready, i_clk, i_rst_n, o_in_ready |-> !o_cmd.rd_en, "axis read issued while accepting requests")
    `DAR_ASSERT_RST(a_idle_after_last, i_clk, i_rst_n, (o_cmd.emit && w_last_port) |=> o_in_ready, "controller busy after final result")
    `DAR_ASSERT_RST(a_addr_in_range, i_clk, i_rst_n, o_cmd.rd_en |-> (int'(r_addr) < NENT), "axis address beyond the value store")

endmodule

FILE: design/dar_dp.sv
// Datapath of the axis ramp: held directions, step computation, axis update and result register.
module dar_dp import dar_pkg::*; #(
    parameter int PORTS         = 4,
    parameter int AXES_PER_PORT = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_in_func,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_cfg_valid,
    input  logic [RATE_W-1:0]      i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_tdata,
    output logic                   o_out_last
);

    localparam int NENT = PORTS * AXES_PER_PORT;
    localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int PW   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int KW   = (AXES_PER_PORT > 1) ? $clog2(AXES_PER_PORT) : 1;

    logic [PORT_FW-1:0]   w_port;
    logic [HELD_W-1:0]    w_held;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [PW-1:0]        w_pidx;
    logic [AXES_PER_PORT-1:0] w_hit;

    logic [RATE_W-1:0]        r_rate;
    logic                     r_enabled;
    logic [HELD_W-1:0]        r_held [PORTS];
    logic [AXES_PER_PORT-1:0] r_active [PORTS];
    logic [NENT-1:0]          r_written;
    logic [ELAPSED_W-1:0]     r_elapsed;
    logic [31:0]              r_prod;
    logic [VAL_W-1:0]         r_step;

    logic                     r_calc_vld;
    logic                     r_calc_wr;
    logic [AW-1:0]            r_calc_addr;
    logic [KW-1:0]            r_calc_k;
    logic [PW-1:0]            r_calc_p;
    logic signed [VAL_W-1:0]  r_row [AXES_PER_PORT];

    logic                     r_out_valid;
    logic [PORT_FW-1:0]       r_out_port;
    logic signed [VAL_W-1:0]  r_out_row [AXES_PER_PORT];
    logic                     r_out_last;

    logic [32:0]              w_sum;
    logic [24:0]              w_shift;
    logic [VAL_W-1:0]         w_rdata;
    logic signed [VAL_W-1:0]  w_cur;
    logic signed [17:0]       w_ext;
    logic signed [17:0]       w_stp;
    logic signed [17:0]       w_add;
    logic signed [17:0]       w_sub;
    logic                     w_act;
    t_dir                     w_dir;
    logic signed [VAL_W-1:0]  w_new;
    logic                     w_deact;

    assign w_port    = i_in_tdata[1:0];
    assign w_held    = i_in_tdata[13:2];
    assign w_elapsed = i_in_tdata[29:14];
    assign w_pidx    = PW'(w_port);

    genvar g;
    generate
        for (g = 0; g < AXES_PER_PORT; g++) begin : g_hit
            assign w_hit[g] = |w_held[2*g +: 2];
        end
    endgenerate

    assign w_sum   = {1'b0, r_prod} + {1'b0, ROUND_HALF};
    assign w_shift = w_sum[32:8];

    dar_ram #(
        .WIDTH(VAL_W),
        .DEPTH(NENT)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (r_calc_vld),
        .i_waddr (r_calc_addr),
        .i_wdata (w_new),
        .i_re    (i_cmd.rd_en),
        .i_raddr (AW'(i_cmd.addr)),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_cur   = r_calc_wr ? signed'(w_rdata) : '0;
        w_ext   = 18'(w_cur);
        w_stp   = signed'({2'b00, r_step});
        w_add   = w_ext + w_stp;
        w_sub   = w_ext - w_stp;
        w_act   = r_active[r_calc_p][r_calc_k];
        w_dir   = t_dir'(r_held[r_calc_p][{r_calc_k, 1'b0} +: 2]);
        w_new   = w_cur;
        w_deact = 1'b0;
        if (w_act) begin
            case (w_dir)
                DIR_POS: w_new = clamp_s16(w_add);
                DIR_NEG: w_new = clamp_s16(w_sub);
                default: begin
                    if (w_cur > 16'sd0) begin
                        w_new = (w_sub < 18'sd0) ? '0 : w_sub[VAL_W-1:0];
                    end else if (w_cur < 16'sd0) begin
                        w_new = (w_add > 18'sd0) ? '0 : w_add[VAL_W-1:0];
                    end else begin
                        w_deact = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_enabled   <= 1'b0;
            r_written   <= '0;
            r_calc_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PORTS; i++) begin
                r_held[i]   <= '0;
                r_active[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            if (i_cmd.accept && (t_func'(i_in_func) == FUNC_UPDATE)) begin
                r_enabled <= 1'b1;
                if (int'(w_port) < PORTS) begin
                    r_held[w_pidx]   <= w_held;
                    r_active[w_pidx] <= r_active[w_pidx] | w_hit;
                end
            end
            r_calc_vld <= i_cmd.rd_en;
            if (r_calc_vld) begin
                r_written[r_calc_addr] <= 1'b1;
                if (w_deact) begin
                    r_active[r_calc_p][r_calc_k] <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_elapsed <= w_elapsed;
        end
        if (i_cmd.mult) begin
            r_prod <= r_elapsed * r_rate;
        end
        if (i_cmd.sat) begin
            r_step <= (|w_shift[24:16]) ? 16'hFFFF : w_shift[15:0];
        end
        if (i_cmd.rd_en) begin
            r_calc_wr   <= r_written[AW'(i_cmd.addr)];
            r_calc_addr <= AW'(i_cmd.addr);
            r_calc_k    <= KW'(i_cmd.axis);
            r_calc_p    <= PW'(i_cmd.port);
        end
        if (r_calc_vld) begin
            r_row[r_calc_k] <= w_new;
        end
        if (i_cmd.emit) begin
            r_out_port <= i_cmd.port[PORT_FW-1:0];
            r_out_row  <= r_row;
            r_out_last <= i_cmd.last_port;
        end
    end

    assign o_status.ramp_enabled = r_enabled;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_tdata[PORT_FW-1:0] = r_out_port;
    assign o_out_tdata[OUT_TDATA_W-1:PORT_FW + MAX_AXES*VAL_W] = '0;

    generate
        for (g = 0; g < MAX_AXES; g++) begin : g_pack
            if (g < AXES_PER_PORT) begin : g_used
                assign o_out_tdata[PORT_FW + g*VAL_W +: VAL_W] = r_out_row[g];
            end else begin : g_unused
                assign o_out_tdata[PORT_FW + g*VAL_W +: VAL_W] = '0;
            end
        end
    endgenerate

endmodule

FILE: design/digital_to_analog_axis_ramp.sv
// Top level of the axis ramp: held directions in, ramped stick values out per port.
// An update request is accepted in the idle state, and the block stays ready.
// A tick first forms the step (multiply, then saturate); then, for each port, it reads
// the port's axes one by one, drains the last read and emits the result once the output
// is free. Ticks are ignored until an update.
// Synchronous reset clears axis values, held directions and active bits; rate becomes 1.0.
module digital_to_analog_axis_ramp import dar_pkg::*; #(
    parameter int PORTS         = 4,
    parameter int AXES_PER_PORT = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // port, held_bits, elapsed_ms
    input  logic                   s_axis_tuser,  // func
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RATE_W-1:0]      i_cfg_data,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_port, stick1_x .. stick3_y
    output logic                   m_axis_tlast
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    dar_ctrl #(
        .PORTS         (PORTS),
        .AXES_PER_PORT (AXES_PER_PORT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dar_dp #(
        .PORTS         (PORTS),
        .AXES_PER_PORT (AXES_PER_PORT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_func   (s_axis_tuser),
        .i_in_tdata  (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

FILE: sim/digital_to_analog_axis_ramp_tb.sv
// Self-checking testbench for the axis ramp: random held-direction and tick requests, predicted stick values.
module digital_to_analog_axis_ramp_tb;
    import dar_pkg::*;

    localparam int NPORTS = 4;
    localparam int NAXES  = 6;

    typedef struct packed {
        logic [PORT_FW-1:0]          port;
        logic [NAXES-1:0][VAL_W-1:0] sticks;
        logic                        last;
    } stick_result_t;

    class axis_ramp_board;
        logic [RATE_W-1:0] rate;
        int                axis_val [NPORTS][NAXES];
        logic [NAXES-1:0]  active [NPORTS];
        logic [HELD_W-1:0] held [NPORTS];
        bit                enabled;
        stick_result_t     expected_sticks [$];
        int                mismatches;
        string             field_name [NAXES];

        function new();
            rate = RATE_RESET;
            enabled = 0;
            mismatches = 0;
            field_name = '{"stick1_x", "stick1_y", "stick2_x", "stick2_y", "stick3_x",
                           "stick3_y"};
            for (int p = 0; p < NPORTS; p++) begin
                active[p] = '0;
                held[p] = '0;
                for (int k = 0; k < NAXES; k++) begin
                    axis_val[p][k] = 0;
                end
            end
        endfunction

        function int pending();
            return expected_sticks.size();
        endfunction

        function void flag_mismatch(string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endfunction

        function void note_request(t_func func, logic [PORT_FW-1:0] port,
                                   logic [HELD_W-1:0] held_bits, logic [ELAPSED_W-1:0] elapsed);
            longint unsigned s;
            int              step;
            int              v;
            t_dir            dir;
            stick_result_t   r;
            if (func == FUNC_UPDATE) begin
                held[port] = held_bits;
                for (int k = 0; k < NAXES; k++) begin
                    if (t_dir'(held_bits[2*k +: 2]) != DIR_NONE) begin
                        active[port][k] = 1'b1;
                    end
                end
                enabled = 1;
                return;
            end
            if (!enabled) begin
                return;
            end
            s = 64'(elapsed);
            s = (s * rate + ROUND_HALF) >> 8;
            step = (s > 65535) ? 65535 : int'(s);
            for (int p = 0; p < NPORTS; p++) begin
                for (int k = 0; k < NAXES; k++) begin
                    if (active[p][k]) begin
                        v = axis_val[p][k];
                        dir = t_dir'(held[p][2*k +: 2]);
                        case (dir)
                            DIR_POS: v = v + step;
                            DIR_NEG: v = v - step;
                            default: begin
                                if (v > 0) begin
                                    v = (v - step < 0) ? 0 : v - step;
                                end else if (v < 0) begin
                                    v = (v + step > 0) ? 0 : v + step;
                                end else begin
                                    active[p][k] = 1'b0;
                                end
                            end
                        endcase
                        if (v > 32767) begin
                            v = 32767;
                        end else if (v < -32768) begin
                            v = -32768;
                        end
                        axis_val[p][k] = v;
                    end
                end
            end
            for (int p = 0; p < NPORTS; p++) begin
                r.port = p[PORT_FW-1:0];
                for (int k = 0; k < NAXES; k++) begin
                    r.sticks[k] = axis_val[p][k][VAL_W-1:0];
                end
                r.last = (p == NPORTS - 1);
                expected_sticks.insert(expected_sticks.size(), r);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            stick_result_t exp_r;
            if (expected_sticks.size() == 0) begin
                flag_mismatch($sformatf("unexpected result for port %0d", tdata[1:0]));
                return;
            end
            exp_r = expected_sticks.pop_front();
            if (tdata[1:0] !== exp_r.port) begin
                flag_mismatch($sformatf("out_port %0d, expected %0d", tdata[1:0], exp_r.port));
            end
            for (int k = 0; k < NAXES; k++) begin
                if (tdata[2+16*k +: 16] !== exp_r.sticks[k]) begin
                    flag_mismatch($sformatf("port %0d %s %0d, expected %0d", exp_r.port,
                                  field_name[k], $signed(tdata[2+16*k +: 16]),
                                  $signed(exp_r.sticks[k])));
                end
            end
            if (tlast !== exp_r.last) begin
                flag_mismatch($sformatf("port %0d last %b, expected %b", exp_r.port, tlast,
                              exp_r.last));
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [RATE_W-1:0]      i_cfg_data;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    axis_ramp_board board = new();
    bit             sender_steady;

    digital_to_analog_axis_ramp #(
        .PORTS         (NPORTS),
        .AXES_PER_PORT (NAXES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic offer_request(t_func func, logic [PORT_FW-1:0] port,
                                 logic [HELD_W-1:0] held_bits, logic [ELAPSED_W-1:0] elapsed);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, elapsed, held_bits, port};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(func, port, held_bits, elapsed);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_ramp_rate(logic [RATE_W-1:0] value);
        drain_results();
        // Updates and ignored ticks leave nothing to wait for, so allow a whole tick to finish.
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.rate = value;
    endtask

    // Result side: random stalls, eager stretches and one long hold-off.
    initial begin
        int stall_left;
        int hold_left;
        int burst_left;
        int results_seen;
        bit eager;
        bit long_hold_done;
        stall_left = 0;
        hold_left = 0;
        burst_left = 100;
        results_seen = 0;
        eager = 0;
        long_hold_done = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tlast);
                results_seen++;
            end
            if (!long_hold_done && results_seen == 40) begin
                long_hold_done = 1;
                hold_left = 400;
            end
            burst_left--;
            if (burst_left == 0) begin
                eager = ($urandom_range(0, 3) == 0);
                burst_left = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!eager && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        logic [RATE_W-1:0] phase_rate [7];
        t_func             func;
        logic [HELD_W-1:0] held_bits;
        logic [ELAPSED_W-1:0] elapsed;
        int                r;
        phase_rate = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'd256, 16'h0000, 16'd128};
        phase_rate[3] = RATE_W'($urandom_range(2, 65534));
        phase_rate[5] = RATE_W'($urandom_range(2, 65534));
        sender_steady = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_UPDATE;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ticks before any update must leave everything untouched and give no result.
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd100);
        offer_request(FUNC_TICK, 2'd3, 12'hFFF, 16'hFFFF);
        offer_request(FUNC_UPDATE, 2'd0, 12'hAAA, 16'h0000);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'hFFFF);
        offer_request(FUNC_UPDATE, 2'd0, 12'h555, 16'hFFFF);
        offer_request(FUNC_TICK, 2'd1, 12'h000, 16'hFFFF);
        offer_request(FUNC_UPDATE, 2'd1, 12'hFFF, 16'h0000);
        offer_request(FUNC_UPDATE, 2'd2, 12'h000, 16'h0000);
        offer_request(FUNC_UPDATE, 2'd3, 12'h6C9, 16'h0000);
        offer_request(FUNC_TICK, 2'd2, 12'h000, 16'h0000);
        offer_request(FUNC_UPDATE, 2'd0, 12'h000, 16'h0000);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd1000);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'hFFFF);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd5);
        offer_request(FUNC_UPDATE, 2'd3, 12'hFFF, 16'h0000);
        offer_request(FUNC_UPDATE, 2'd2, 12'h0A9, 16'h0000);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd300);
        offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd300);

        for (int ph = 0; ph < 7; ph++) begin
            write_ramp_rate(phase_rate[ph]);
            sender_steady = (ph == 4);
            if (phase_rate[ph] == 16'h0001) begin
                // Rounding at the half-way point of the fixed-point step.
                offer_request(FUNC_UPDATE, 2'd1, 12'hA5A, 16'h0000);
                offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd128);
                offer_request(FUNC_TICK, 2'd0, 12'h000, 16'd127);
            end
            for (int n = 0; n < 34; n++) begin
                if (ph == 2 && n == 18) begin
                    drain_results();
                end
                func = ($urandom_range(0, 99) < 40) ? FUNC_TICK : FUNC_UPDATE;
                for (int k = 0; k < NAXES; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        held_bits[2*k +: 2] = DIR_POS;
                    end else if (r < 8) begin
                        held_bits[2*k +: 2] = DIR_NEG;
                    end else if (r == 8) begin
                        held_bits[2*k +: 2] = DIR_NONE;
                    end else begin
                        held_bits[2*k +: 2] = DIR_BOTH;
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    held_bits = HELD_W'($urandom);
                end
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    elapsed = ELAPSED_W'($urandom_range(0, 64));
                end else if (r < 9) begin
                    elapsed = ELAPSED_W'($urandom_range(64, 1023));
                end else begin
                    elapsed = ELAPSED_W'($urandom);
                end
                offer_request(func, PORT_FW'($urandom_range(0, 3)), held_bits, elapsed);
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
